// ===== src/socd_dpad_cleaner_core_assert.svh =====
// ---------------------------------------------------------------------------
// socd d-pad cleaner assertion macros
// shared property forms for the checker, clocked on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef SOCD_DPAD_CLEANER_CORE_ASSERT_SVH
`define SOCD_DPAD_CLEANER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SOCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("socd check failed");

// antecedent implies consequent in the next cycle
`define SOCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("socd check failed");

`endif

// ===== src/socd_pkg.sv =====
// ---------------------------------------------------------------------------
// socd_pkg
// mode, direction and axis codes shared by the d-pad cleaner modules
// ---------------------------------------------------------------------------
package socd_pkg;

  localparam int DPAD_W = 4;
  localparam int MODE_W = 3;

  // socd_mode register codes
  localparam logic [MODE_W-1:0] MODE_UP_PRIO   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NEUTRAL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LAST_WIN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIRST_WIN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BYPASS    = 3'd4;

  // per-axis resolution codes
  localparam logic [1:0] AX_UP_PRIO   = 2'd0;
  localparam logic [1:0] AX_NEUTRAL   = 2'd1;
  localparam logic [1:0] AX_LAST_WIN  = 2'd2;
  localparam logic [1:0] AX_FIRST_WIN = 2'd3;

  // remembered direction of one axis
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_A    = 2'd1;
  localparam logic [1:0] DIR_B    = 2'd2;

  // two-bit axis press patterns, bit0 is up or left, bit1 is down or right
  localparam logic [1:0] PRESS_NONE = 2'b00;
  localparam logic [1:0] PRESS_A    = 2'b01;
  localparam logic [1:0] PRESS_B    = 2'b10;
  localparam logic [1:0] PRESS_BOTH = 2'b11;

  typedef struct packed {
    logic [1:0] bits;
    logic [1:0] last;
  } axis_res_t;

endpackage

// ===== src/socd_axis.sv =====
// ---------------------------------------------------------------------------
// socd_axis
// resolves one d-pad axis and computes its next remembered direction
// ---------------------------------------------------------------------------
module socd_axis
  import socd_pkg::*;
(
  input  logic [1:0] amode,
  input  logic [1:0] bits,
  input  logic [1:0] last,
  output axis_res_t  res
);

  always_comb begin
    res.bits = PRESS_NONE;
    res.last = DIR_NONE;
    case (bits)
      PRESS_BOTH: begin
        if (amode == AX_UP_PRIO) begin
          res.bits = PRESS_A;
          res.last = DIR_A;
        end else if (amode == AX_LAST_WIN && last != DIR_NONE) begin
          // opposite of the remembered press
          res.bits = (last == DIR_A) ? PRESS_B : PRESS_A;
          res.last = last;
        end else if (amode == AX_FIRST_WIN && last != DIR_NONE) begin
          res.bits = (last == DIR_A) ? PRESS_A : PRESS_B;
          res.last = last;
        end
      end
      PRESS_A: begin
        res.bits = PRESS_A;
        res.last = DIR_A;
      end
      PRESS_B: begin
        res.bits = PRESS_B;
        res.last = DIR_B;
      end
      default: begin
        res.bits = PRESS_NONE;
        res.last = DIR_NONE;
      end
    endcase
  end

endmodule

// ===== src/socd_dpad_cleaner_core.sv =====
// ---------------------------------------------------------------------------
// socd_dpad_cleaner_core
// d-pad cleaner that resolves simultaneous opposing presses per axis
// ---------------------------------------------------------------------------
// Takes one d-pad sample per cycle while in_tready is high and returns one
// cleaned sample per request. A sample is captured in an input register,
// resolved against the two per-axis direction registers once the output
// register is free, and lands in the output register, which drives
// out_tvalid. Throughput is one sample per clock while out_tready does not
// stall the output, set by the input and output registers and the per-axis
// state update done as each sample enters the output register. The input
// side keeps accepting while a result waits as long as the input register
// is free. socd_mode is written through cfg_we/cfg_wdata; the user must
// write it only while no sample is in flight, as the block does not enforce
// it. Codes 5 to 7 behave as neutral, and bypass passes samples through
// untouched without changing the remembered directions.
module socd_dpad_cleaner_core
  import socd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [3:0] dpad_in, [7:4] zero
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [3:0] dpad_out, [7:4] zero
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [DPAD_W-1:0] s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DPAD_W-1:0] out_data_r;
  logic [MODE_W-1:0] mode_r;
  logic [1:0]        last_v_r, last_h_r;

  logic              out_free;
  logic              advance;
  logic              in_accept;
  logic              bypass;
  logic [1:0]        vmode, hmode;
  axis_res_t         v_res, h_res;
  logic [DPAD_W-1:0] resolved;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_accept = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_comb begin
    bypass = 1'b0;
    unique case (mode_r)
      MODE_UP_PRIO: begin
        vmode = AX_UP_PRIO;
        hmode = AX_NEUTRAL;
      end
      MODE_LAST_WIN: begin
        vmode = AX_LAST_WIN;
        hmode = AX_LAST_WIN;
      end
      MODE_FIRST_WIN: begin
        vmode = AX_FIRST_WIN;
        hmode = AX_FIRST_WIN;
      end
      MODE_BYPASS: begin
        bypass = 1'b1;
        vmode  = AX_NEUTRAL;
        hmode  = AX_NEUTRAL;
      end
      default: begin
        vmode = AX_NEUTRAL;
        hmode = AX_NEUTRAL;
      end
    endcase
  end

  socd_axis u_axis_v (
    .amode (vmode),
    .bits  (s1_data_r[1:0]),
    .last  (last_v_r),
    .res   (v_res)
  );

  socd_axis u_axis_h (
    .amode (hmode),
    .bits  (s1_data_r[3:2]),
    .last  (last_h_r),
    .res   (h_res)
  );

  assign resolved = bypass ? s1_data_r : {h_res.bits, v_res.bits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_NEUTRAL;
      last_v_r    <= DIR_NONE;
      last_h_r    <= DIR_NONE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      // bypass leaves the remembered directions alone
      if (advance && !bypass) begin
        last_v_r <= v_res.last;
        last_h_r <= h_res.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_tdata[DPAD_W-1:0];
    end
    if (advance) begin
      out_data_r <= resolved;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r};

endmodule

// ===== src/socd_chk.sv =====
// ---------------------------------------------------------------------------
// socd_chk
// port-level checks on the d-pad cleaner, bound to the top level
// ---------------------------------------------------------------------------
`include "socd_dpad_cleaner_core_assert.svh"

module socd_chk
  import socd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [7:0]        out_tdata,  // [3:0] dpad_out, [7:4] zero
  input logic              cfg_we,
  input logic [MODE_W-1:0] cfg_wdata
);

  logic [MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NEUTRAL;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // a stalled result holds
  `SOCD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata))
  // input side only backs up when the result side is stalled
  `SOCD_ASSERT_SAME(a_in_stall, in_tvalid && !in_tready,
                    out_tvalid && !out_tready)
  // both vertical presses only reach the output in bypass
  `SOCD_ASSERT_SAME(a_vert_clean, out_tvalid && out_tdata[1:0] == PRESS_BOTH,
                    mode_r == MODE_BYPASS)
  // both horizontal presses only reach the output in bypass
  `SOCD_ASSERT_SAME(a_horz_clean, out_tvalid && out_tdata[3:2] == PRESS_BOTH,
                    mode_r == MODE_BYPASS)

endmodule

bind socd_dpad_cleaner_core socd_chk u_socd_chk (.*);

// ===== tb/sv/socd_dpad_cleaner_core_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// socd_dpad_cleaner_core_test
// drives d-pad samples through the cleaner under every socd mode, predicts the
// cleaned d-pad per axis with its own copy of the remembered directions, and
// checks each result in order while both stream sides stall at random
// ---------------------------------------------------------------------------
module socd_dpad_cleaner_core_test;
  import socd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 80;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;    // [3:0] dpad_in, [7:4] zero
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;   // [3:0] dpad_out, [7:4] zero
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;

  // shadow of the block's register and per-axis memory
  logic [MODE_W-1:0] mode_shadow = MODE_NEUTRAL;
  logic [1:0]        last_vert   = DIR_NONE;
  logic [1:0]        last_horiz  = DIR_NONE;

  logic [DPAD_W-1:0] cleaned_dpad_q[$];
  int                fail_cnt   = 0;
  int                cycle_cnt  = 0;
  int                ready_hold = 0;
  bit                idle_en    = 1'b0;

  socd_dpad_cleaner_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic axis_res_t resolve_axis(logic [1:0] amode, logic [1:0] press,
                                             logic [1:0] last);
    axis_res_t r;
    r.bits = PRESS_NONE;
    r.last = last;
    case (press)
      PRESS_BOTH: begin
        if (amode == AX_UP_PRIO) begin
          r.bits = PRESS_A;
          r.last = DIR_A;
        end else if (amode == AX_LAST_WIN && last != DIR_NONE) begin
          r.bits = (last == DIR_A) ? PRESS_B : PRESS_A;
        end else if (amode == AX_FIRST_WIN && last != DIR_NONE) begin
          r.bits = (last == DIR_A) ? PRESS_A : PRESS_B;
        end else begin
          r.last = DIR_NONE;
        end
      end
      PRESS_A: begin
        r.bits = PRESS_A;
        r.last = DIR_A;
      end
      PRESS_B: begin
        r.bits = PRESS_B;
        r.last = DIR_B;
      end
      default: r.last = DIR_NONE;
    endcase
    return r;
  endfunction

  // updates the shadow memory, so call once per accepted sample
  function automatic logic [DPAD_W-1:0] clean_dpad(logic [DPAD_W-1:0] raw);
    logic [1:0] vmode;
    logic [1:0] hmode;
    axis_res_t  v;
    axis_res_t  h;
    if (mode_shadow == MODE_BYPASS) return raw;
    case (mode_shadow)
      MODE_UP_PRIO: begin
        vmode = AX_UP_PRIO;
        hmode = AX_NEUTRAL;
      end
      MODE_LAST_WIN: begin
        vmode = AX_LAST_WIN;
        hmode = AX_LAST_WIN;
      end
      MODE_FIRST_WIN: begin
        vmode = AX_FIRST_WIN;
        hmode = AX_FIRST_WIN;
      end
      default: begin
        vmode = AX_NEUTRAL;
        hmode = AX_NEUTRAL;
      end
    endcase
    v = resolve_axis(vmode, raw[1:0], last_vert);
    h = resolve_axis(hmode, raw[3:2], last_horiz);
    last_vert  = v.last;
    last_horiz = h.last;
    return {h.bits, v.bits};
  endfunction

  // predict at each accepted request
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      cleaned_dpad_q.insert(cleaned_dpad_q.size(), clean_dpad(in_tdata[DPAD_W-1:0]));
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cleaned_dpad_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        fail_cnt++;
      end else if (out_tdata !== {4'b0, cleaned_dpad_q[0]}) begin
        $display("%0t: dpad_out mismatch, expected %h, got %h", $time,
                 {4'b0, cleaned_dpad_q[0]}, out_tdata);
        fail_cnt++;
        void'(cleaned_dpad_q.pop_front());
      end else begin
        void'(cleaned_dpad_q.pop_front());
      end
    end
  end

  // random result side back-pressure while idle_en is set
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      ready_hold <= $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** socd_dpad_cleaner_core: FAILED **");
      $finish;
    end
  end

  // leaves in_tvalid high after acceptance so back-to-back requests stay valid
  task automatic send_dpad(input logic [DPAD_W-1:0] raw);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, raw};
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid, let the last request reach the predictor, wait for every result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cleaned_dpad_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_socd_mode(input logic [MODE_W-1:0] mode);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we      <= 1'b0;
    mode_shadow = mode;
  endtask

  task automatic test_reset_neutral();
    send_dpad(4'h0);
    send_dpad(4'hF);
    send_dpad(4'h1);
    send_dpad(4'h3);
    send_dpad(4'hC);
  endtask

  task automatic test_up_priority();
    set_socd_mode(MODE_UP_PRIO);
    send_dpad(4'h3);
    send_dpad(4'hF);
    send_dpad(4'h6);
  endtask

  task automatic test_last_win();
    set_socd_mode(MODE_LAST_WIN);
    send_dpad(4'h0);
    send_dpad(4'h3);    // nothing remembered yet
    send_dpad(4'h2);
    send_dpad(4'h3);
    send_dpad(4'h9);
    send_dpad(4'hF);
  endtask

  task automatic test_first_win();
    set_socd_mode(MODE_FIRST_WIN);
    send_dpad(4'h0);
    send_dpad(4'h5);
    send_dpad(4'hF);
    send_dpad(4'hA);
    send_dpad(4'hF);
  endtask

  // bypass must leave the remembered directions alone
  task automatic test_bypass();
    set_socd_mode(MODE_LAST_WIN);
    send_dpad(4'h5);
    set_socd_mode(MODE_BYPASS);
    send_dpad(4'hF);
    send_dpad(4'h0);
    set_socd_mode(MODE_LAST_WIN);
    send_dpad(4'hF);
  endtask

  task automatic test_undefined_modes();
    for (int k = 1; k <= 3; k++) begin
      set_socd_mode(MODE_W'(MODE_BYPASS + k));
      send_dpad(4'h9);
      send_dpad(4'hF);
    end
  endtask

  // mostly held presses that turn into opposing ones, with some raw noise
  task automatic test_random_play();
    logic [1:0] vpress;
    logic [1:0] hpress;
    int         pick;
    vpress = PRESS_NONE;
    hpress = PRESS_NONE;
    for (int p = 0; p < PHASES; p++) begin
      set_socd_mode(p < 8 ? MODE_W'(p) : MODE_W'($urandom_range(0, 7)));
      idle_en = (p < PHASES - 2) && (p % 3 != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_dpad(4'($urandom_range(0, 15)));
        end else begin
          if ($urandom_range(0, 1) == 0) begin
            pick   = $urandom_range(0, 9);
            vpress = pick < 5 ? ($urandom_range(0, 1) ? PRESS_A : PRESS_B) :
                     pick < 8 ? PRESS_BOTH : PRESS_NONE;
          end
          if ($urandom_range(0, 1) == 0) begin
            pick   = $urandom_range(0, 9);
            hpress = pick < 5 ? ($urandom_range(0, 1) ? PRESS_A : PRESS_B) :
                     pick < 8 ? PRESS_BOTH : PRESS_NONE;
          end
          send_dpad({hpress, vpress});
        end
      end
    end
    idle_en = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    cfg_we    = 1'b0;
    cfg_wdata = MODE_NEUTRAL;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_en = 1'b1;

    test_reset_neutral();
    test_up_priority();
    test_last_win();
    test_first_win();
    test_bypass();
    test_undefined_modes();
    test_random_play();

    drain_results();
    if (fail_cnt == 0) begin
      $display("** socd_dpad_cleaner_core: PASSED **");
    end else begin
      $display("** socd_dpad_cleaner_core: FAILED **");
    end
    $finish;
  end

endmodule
